@@ rtl/smpg_pkg.sv @@
// Shared types, field widths, codes and reset values for the step pulse generator.
package smpg_pkg;

   // Item field widths
   localparam int ACTION_W      = 3;
   localparam int AMOUNT_W      = 24;
   localparam int REV_MS_W      = 20;
   localparam int IMP_W         = 16;
   localparam int STEPS_OUT_W   = 24;

   // Register widths
   localparam int PW_W          = 10;
   localparam int SPR_W         = 16;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 20;

   // Arithmetic widths
   localparam int US_PER_MS          = 1000;
   localparam int US_W               = 10;
   localparam int REV_FRACTION_SHIFT = 8;
   localparam int DIV_NUM_W          = AMOUNT_W + SPR_W;
   localparam int DIV_DEN_W          = REV_MS_W;
   localparam int DIV_CNT_W          = $clog2(DIV_NUM_W + 1);
   localparam int PERIOD_NUM_W       = REV_MS_W + US_W;
   localparam int WIDE_W             = 40;

   // Parameter defaults
   localparam int STEP_COUNT_BITS_DEFAULT = 24;
   localparam int PERIOD_BITS_DEFAULT     = 32;

   // Command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Reset values
   localparam int PERIOD_RESET_US = 10000;

   typedef logic [ACTION_W-1:0] action_type;

   localparam action_type ACT_TICK      = 3'd0;
   localparam action_type ACT_MOVE_REV  = 3'd1;
   localparam action_type ACT_MOVE_TIME = 3'd2;
   localparam action_type ACT_MOVE_IMP  = 3'd3;
   localparam action_type ACT_START     = 3'd4;
   localparam action_type ACT_STOP      = 3'd5;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_PULSE_WIDTH  = 3'd0;
   localparam csr_index_type CSR_STEPS_PER_REV = 3'd1;
   localparam csr_index_type CSR_IMP_LOW      = 3'd2;
   localparam csr_index_type CSR_IMP_HIGH     = 3'd3;
   localparam csr_index_type CSR_FAST_BAND    = 3'd4;
   localparam csr_index_type CSR_MIDDLE_BAND  = 3'd5;
   localparam csr_index_type CSR_SLOW_BAND    = 3'd6;

   typedef logic [2:0] op_type;

   localparam op_type OP_TICK       = 3'd0;
   localparam op_type OP_MOVE_SHIFT = 3'd1;
   localparam op_type OP_MOVE_DIV   = 3'd2;
   localparam op_type OP_START      = 3'd3;
   localparam op_type OP_STOP       = 3'd4;
   localparam op_type OP_NOP        = 3'd5;

   typedef struct packed {
      action_type          action;
      logic [AMOUNT_W-1:0] amount;
      logic [REV_MS_W-1:0] rev_period_ms;
      logic                direction;
      logic [IMP_W-1:0]    impedance;
   } req_item_type;

   typedef struct packed {
      logic                   step_level;
      logic                   dir_level;
      logic                   is_running;
      logic [STEPS_OUT_W-1:0] steps_left;
   } rsp_item_type;

   typedef struct packed {
      logic [PW_W-1:0]     pulse_width_ticks;
      logic [SPR_W-1:0]    steps_per_revolution;
      logic [IMP_W-1:0]    impedance_low_limit;
      logic [IMP_W-1:0]    impedance_high_limit;
      logic [REV_MS_W-1:0] fast_band_rev_ms;
      logic [REV_MS_W-1:0] middle_band_rev_ms;
      logic [REV_MS_W-1:0] slow_band_rev_ms;
   } cfg_type;

   typedef struct packed {
      op_type                  op;
      logic                    direction;
      logic [DIV_NUM_W-1:0]    steps_num;
      logic [DIV_DEN_W-1:0]    steps_den;
      logic [PERIOD_NUM_W-1:0] period_num;
   } cmd_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ rtl/smpg_req_if.sv @@
// Request channel interface: valid, ready and one request item.
interface smpg_req_if;
   logic                  valid;
   logic                  ready;
   smpg_pkg::req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/smpg_rsp_if.sv @@
// Response channel interface: valid, ready and one result item.
interface smpg_rsp_if;
   logic                  valid;
   logic                  ready;
   smpg_pkg::rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/smpg_front.sv @@
// Front end: accepts request items, picks the speed band and forms the operands.
module smpg_front (
   smpg_req_if.sink           req_ch,
   input  smpg_pkg::cfg_type  cfg,
   input  logic               q_full,
   output logic               push,
   output smpg_pkg::cmd_type  push_cmd
);

   localparam int NUM_W  = smpg_pkg::DIV_NUM_W;
   localparam int PNUM_W = smpg_pkg::PERIOD_NUM_W;

   logic [smpg_pkg::REV_MS_W-1:0] band_ms;
   logic [smpg_pkg::REV_MS_W-1:0] rev_ms_sel;
   logic                          is_imp;

   assign req_ch.ready = !q_full;
   assign push         = req_ch.valid && !q_full;
   assign is_imp       = (req_ch.data.action == smpg_pkg::ACT_MOVE_IMP);

   // Pick the band by impedance: below low is fast, up to high is middle
   always_comb begin
      priority if (req_ch.data.impedance < cfg.impedance_low_limit) begin
         band_ms = cfg.fast_band_rev_ms;
      end else if (req_ch.data.impedance <= cfg.impedance_high_limit) begin
         band_ms = cfg.middle_band_rev_ms;
      end else begin
         band_ms = cfg.slow_band_rev_ms;
      end
   end

   assign rev_ms_sel = is_imp ? band_ms : req_ch.data.rev_period_ms;

   always_comb begin
      push_cmd.direction  = is_imp ? 1'b1 : req_ch.data.direction;
      push_cmd.steps_num  = NUM_W'(req_ch.data.amount) * NUM_W'(cfg.steps_per_revolution);
      push_cmd.steps_den  = rev_ms_sel;
      push_cmd.period_num = PNUM_W'(rev_ms_sel) * PNUM_W'(smpg_pkg::US_PER_MS);
      unique case (req_ch.data.action)
         smpg_pkg::ACT_TICK:      push_cmd.op = smpg_pkg::OP_TICK;
         smpg_pkg::ACT_MOVE_REV:  push_cmd.op = smpg_pkg::OP_MOVE_SHIFT;
         smpg_pkg::ACT_MOVE_TIME: push_cmd.op = smpg_pkg::OP_MOVE_DIV;
         smpg_pkg::ACT_MOVE_IMP:  push_cmd.op = smpg_pkg::OP_MOVE_DIV;
         smpg_pkg::ACT_START:     push_cmd.op = smpg_pkg::OP_START;
         smpg_pkg::ACT_STOP:      push_cmd.op = smpg_pkg::OP_STOP;
         default:                 push_cmd.op = smpg_pkg::OP_NOP;
      endcase
   end

endmodule

@@ rtl/smpg_cmd_queue.sv @@
// Short command queue between the front end and the step engine.
module smpg_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  smpg_pkg::cmd_type push_cmd,
   input  logic              pop,
   output smpg_pkg::cmd_type pop_cmd,
   output logic              full,
   output logic              empty
);

   localparam int DEPTH = smpg_pkg::QUEUE_DEPTH;
   localparam int PTR_W = smpg_pkg::QUEUE_PTR_W;
   localparam int CNT_W = smpg_pkg::QUEUE_CNT_W;

   smpg_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/smpg_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module smpg_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  smpg_pkg::div_req_type div_req,
   output smpg_pkg::div_rsp_type div_rsp
);

   localparam int NUM_W = smpg_pkg::DIV_NUM_W;
   localparam int DEN_W = smpg_pkg::DIV_DEN_W;
   localparam int CNT_W = smpg_pkg::DIV_CNT_W;

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = (shifted >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         den_in  = div_req.divisor;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Subtract when the shifted remainder covers the divisor
         rem_in = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

@@ rtl/smpg_back.sv @@
// Step engine: runs commands in order, drives the divider and the result register.
module smpg_back #(
   parameter int STEP_COUNT_BITS = smpg_pkg::STEP_COUNT_BITS_DEFAULT,
   parameter int PERIOD_BITS     = smpg_pkg::PERIOD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  smpg_pkg::cfg_type     cfg,
   input  logic                  q_empty,
   input  smpg_pkg::cmd_type     q_cmd,
   output logic                  pop,
   output smpg_pkg::div_req_type div_req,
   input  smpg_pkg::div_rsp_type div_rsp,
   smpg_rsp_if.source            rsp_ch
);

   localparam int NUM_W  = smpg_pkg::DIV_NUM_W;
   localparam int DEN_W  = smpg_pkg::DIV_DEN_W;
   localparam int WIDE_W = smpg_pkg::WIDE_W;
   localparam int OUT_W  = smpg_pkg::STEPS_OUT_W;

   localparam logic [STEP_COUNT_BITS-1:0] COUNT_MAX  = '1;
   localparam logic [PERIOD_BITS-1:0]     PERIOD_MAX = '1;
   localparam logic [OUT_W-1:0]           OUT_MAX    = '1;

   localparam logic [2:0] ST_IDLE        = 3'd0;
   localparam logic [2:0] ST_STEPS_GO    = 3'd1;
   localparam logic [2:0] ST_STEPS_WAIT  = 3'd2;
   localparam logic [2:0] ST_PERIOD_GO   = 3'd3;
   localparam logic [2:0] ST_PERIOD_WAIT = 3'd4;
   localparam logic [2:0] ST_FINISH      = 3'd5;

   function automatic logic [STEP_COUNT_BITS-1:0] sat_steps(input logic [NUM_W-1:0] v);
      return ((v >> STEP_COUNT_BITS) != '0) ? COUNT_MAX : v[STEP_COUNT_BITS-1:0];
   endfunction

   function automatic logic [PERIOD_BITS-1:0] sat_period(input logic [NUM_W-1:0] v);
      return ((v >> PERIOD_BITS) != '0) ? PERIOD_MAX : v[PERIOD_BITS-1:0];
   endfunction

   function automatic logic [OUT_W-1:0] sat_out(input logic [STEP_COUNT_BITS-1:0] r);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(r);
      return (w > WIDE_W'(OUT_MAX)) ? OUT_MAX : w[OUT_W-1:0];
   endfunction

   logic [2:0]                 state_ff, state_in;
   smpg_pkg::cmd_type          cmd_ff, cmd_in;
   logic [STEP_COUNT_BITS-1:0] new_steps_ff, new_steps_in;
   logic [PERIOD_BITS-1:0]     new_period_ff, new_period_in;

   logic                       running_ff, running_in;
   logic                       move_dir_ff, move_dir_in;
   logic                       dir_pin_ff, dir_pin_in;
   logic [STEP_COUNT_BITS-1:0] remaining_ff, remaining_in;
   logic [PERIOD_BITS-1:0]     period_ff, period_in;
   logic [PERIOD_BITS-1:0]     phase_ff, phase_in;
   logic                       step_active_ff, step_active_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   smpg_pkg::rsp_item_type     rsp_data_ff, rsp_data_in;

   logic                       slot_free;
   logic                       rsp_fire;
   logic                       level;
   logic [PERIOD_BITS-1:0]     pw_ext;
   logic [PERIOD_BITS-1:0]     step_len;
   logic [PERIOD_BITS-1:0]     phase_step;

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_fire  = (state_ff == ST_FINISH) && slot_free;
   assign pw_ext    = PERIOD_BITS'(cfg.pulse_width_ticks);

   // Step length is the longest of period, pulse width and one tick
   always_comb begin
      step_len = (period_ff < pw_ext) ? pw_ext : period_ff;
      if (step_len == '0) begin
         step_len = PERIOD_BITS'(1);
      end
   end

   // Sequencer: pop, run the divisions that a move needs, then finish
   always_comb begin
      state_in         = state_ff;
      cmd_in           = cmd_ff;
      new_steps_in     = new_steps_ff;
      new_period_in    = new_period_ff;
      pop              = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = cmd_ff.steps_num;
      div_req.divisor  = cmd_ff.steps_den;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               pop    = 1'b1;
               cmd_in = q_cmd;
               unique case (q_cmd.op)
                  smpg_pkg::OP_MOVE_SHIFT: begin
                     new_steps_in = sat_steps(q_cmd.steps_num >> smpg_pkg::REV_FRACTION_SHIFT);
                     state_in     = ST_PERIOD_GO;
                  end
                  smpg_pkg::OP_MOVE_DIV: state_in = ST_STEPS_GO;
                  default:               state_in = ST_FINISH;
               endcase
            end
         end
         ST_STEPS_GO: begin
            if (cmd_ff.steps_den == '0) begin
               new_steps_in = COUNT_MAX;
               state_in     = ST_PERIOD_GO;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_STEPS_WAIT;
            end
         end
         ST_STEPS_WAIT: begin
            if (div_rsp.done) begin
               new_steps_in = sat_steps(div_rsp.quotient);
               state_in     = ST_PERIOD_GO;
            end
         end
         ST_PERIOD_GO: begin
            div_req.dividend = NUM_W'(cmd_ff.period_num);
            div_req.divisor  = DEN_W'(cfg.steps_per_revolution);
            if (cfg.steps_per_revolution == '0) begin
               new_period_in = PERIOD_MAX;
               state_in      = ST_FINISH;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_PERIOD_WAIT;
            end
         end
         ST_PERIOD_WAIT: begin
            if (div_rsp.done) begin
               new_period_in = sat_period(div_rsp.quotient);
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Apply the command to the step state and form the result
   always_comb begin
      running_in     = running_ff;
      move_dir_in    = move_dir_ff;
      dir_pin_in     = dir_pin_ff;
      remaining_in   = remaining_ff;
      period_in      = period_ff;
      phase_in       = phase_ff;
      step_active_in = step_active_ff;
      level          = step_active_ff && (phase_ff < pw_ext);
      phase_step     = phase_ff + PERIOD_BITS'(1);
      if (rsp_fire) begin
         unique case (cmd_ff.op)
            smpg_pkg::OP_TICK: begin
               if (!step_active_ff && running_ff && (remaining_ff != '0)) begin
                  dir_pin_in     = move_dir_ff;
                  step_active_in = 1'b1;
                  phase_in       = '0;
               end
               phase_step = phase_in + PERIOD_BITS'(1);
               if (step_active_in) begin
                  level = (phase_in < pw_ext);
                  if (phase_step >= step_len) begin
                     step_active_in = 1'b0;
                     phase_in       = '0;
                     if (remaining_ff != '0) begin
                        remaining_in = remaining_ff - STEP_COUNT_BITS'(1);
                     end
                     if (remaining_in == '0) begin
                        running_in = 1'b0;
                     end
                  end else begin
                     phase_in = phase_step;
                  end
               end else begin
                  level = 1'b0;
               end
            end
            smpg_pkg::OP_MOVE_SHIFT,
            smpg_pkg::OP_MOVE_DIV: begin
               move_dir_in  = cmd_ff.direction;
               period_in    = new_period_ff;
               remaining_in = new_steps_ff;
               running_in   = 1'b1;
            end
            smpg_pkg::OP_START: running_in = 1'b1;
            smpg_pkg::OP_STOP:  running_in = 1'b0;
            default: ;
         endcase
      end
      rsp_data_in.step_level = level;
      rsp_data_in.dir_level  = dir_pin_in;
      rsp_data_in.is_running = running_in;
      rsp_data_in.steps_left = sat_out(remaining_in);
      rsp_valid_in = rsp_fire || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         running_ff     <= 1'b0;
         move_dir_ff    <= 1'b0;
         dir_pin_ff     <= 1'b1;
         remaining_ff   <= '0;
         period_ff      <= PERIOD_BITS'(smpg_pkg::PERIOD_RESET_US);
         phase_ff       <= '0;
         step_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         running_ff     <= running_in;
         move_dir_ff    <= move_dir_in;
         dir_pin_ff     <= dir_pin_in;
         remaining_ff   <= remaining_in;
         period_ff      <= period_in;
         phase_ff       <= phase_in;
         step_active_ff <= step_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      new_steps_ff  <= new_steps_in;
      new_period_ff <= new_period_in;
      if (rsp_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule

@@ rtl/stepper_move_pulse_generator.sv @@
// Top level of the step and direction pulse generator.
//
//   channel   dir   handshake              item
//   req_ch    in    valid/ready            action, amount, rev_period_ms, direction, impedance
//   rsp_ch    out   valid/ready            step_level, dir_level, is_running, steps_left
//   csr_*     in    csr_we, no wait        csr_index selects register, csr_wdata value
//
// Tick, start, stop and unused actions pass only the pop and finish states of the step
// engine, pop then finish; no division runs for them.
// In a move the step count and the step period each go through the shared
// restoring divider, one quotient bit per cycle over 40 bits; a revolutions
// move skips the first division.
// Reset is synchronous and active high; it restores register defaults and clears
// the queue, the divider and the step state. A held result stalls the step engine
// only; the front end keeps filling the two-entry queue until it is full.
module stepper_move_pulse_generator #(
   parameter int STEP_COUNT_BITS = smpg_pkg::STEP_COUNT_BITS_DEFAULT,
   parameter int PERIOD_BITS     = smpg_pkg::PERIOD_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   smpg_req_if.sink                          req_ch,
   smpg_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [smpg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [smpg_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   smpg_pkg::cfg_type     cfg_ff, cfg_in;
   logic                  q_push;
   logic                  q_pop;
   logic                  q_full;
   logic                  q_empty;
   smpg_pkg::cmd_type     push_cmd;
   smpg_pkg::cmd_type     pop_cmd;
   smpg_pkg::div_req_type div_req;
   smpg_pkg::div_rsp_type div_rsp;

   // Register file: take a write whenever the enable is high, drop unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            smpg_pkg::CSR_PULSE_WIDTH:
               cfg_in.pulse_width_ticks = csr_wdata[smpg_pkg::PW_W-1:0];
            smpg_pkg::CSR_STEPS_PER_REV:
               cfg_in.steps_per_revolution = csr_wdata[smpg_pkg::SPR_W-1:0];
            smpg_pkg::CSR_IMP_LOW:
               cfg_in.impedance_low_limit = csr_wdata[smpg_pkg::IMP_W-1:0];
            smpg_pkg::CSR_IMP_HIGH:
               cfg_in.impedance_high_limit = csr_wdata[smpg_pkg::IMP_W-1:0];
            smpg_pkg::CSR_FAST_BAND:
               cfg_in.fast_band_rev_ms = csr_wdata[smpg_pkg::REV_MS_W-1:0];
            smpg_pkg::CSR_MIDDLE_BAND:
               cfg_in.middle_band_rev_ms = csr_wdata[smpg_pkg::REV_MS_W-1:0];
            smpg_pkg::CSR_SLOW_BAND:
               cfg_in.slow_band_rev_ms = csr_wdata[smpg_pkg::REV_MS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_width_ticks    <= smpg_pkg::PW_W'(10);
         cfg_ff.steps_per_revolution <= smpg_pkg::SPR_W'(200);
         cfg_ff.impedance_low_limit  <= smpg_pkg::IMP_W'(117);
         cfg_ff.impedance_high_limit <= smpg_pkg::IMP_W'(137);
         cfg_ff.fast_band_rev_ms     <= smpg_pkg::REV_MS_W'(10000);
         cfg_ff.middle_band_rev_ms   <= smpg_pkg::REV_MS_W'(30000);
         cfg_ff.slow_band_rev_ms     <= smpg_pkg::REV_MS_W'(50000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: classify the item and form the multiplied operands
   smpg_front u_front (
      .req_ch   (req_ch),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .push     (q_push),
      .push_cmd (push_cmd)
   );

   // Queue: decouple acceptance from execution
   smpg_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   // Shared divider for step counts and step periods
   smpg_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Step engine: hold the step state and present one result per item
   smpg_back #(
      .STEP_COUNT_BITS (STEP_COUNT_BITS),
      .PERIOD_BITS     (PERIOD_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_empty (q_empty),
      .q_cmd   (pop_cmd),
      .pop     (q_pop),
      .div_req (div_req),
      .div_rsp (div_rsp),
      .rsp_ch  (rsp_ch)
   );

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("item pushed into a full queue");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("item popped from an empty queue");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_start_then_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> div_rsp.busy)
      else $error("divider did not go busy after start");

endmodule
